// ===== rtl/cpr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants of the complex phase rotator
// Fixed-point formats, the CORDIC arctangent table and the request and
// response payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

   // Field widths
   localparam int CPR_SAMPLE_WIDTH = 16;
   localparam int CPR_PHASE_WIDTH  = 16;

   // Internal angle: a full turn is 2^32
   localparam int CPR_ANGLE_WIDTH  = 32;
   localparam int CPR_ITERS        = 30;
   localparam int CPR_FRAC         = 30;
   localparam int CPR_SHIFT_WIDTH  = $clog2(CPR_ITERS);

   // Quarter-rotated sample needs one bit more than the input
   localparam int CPR_QUAD_WIDTH   = CPR_SAMPLE_WIDTH + 1;
   // Product width of sample and gain constant
   localparam int CPR_PROD_WIDTH   = CPR_QUAD_WIDTH + 31;
   // Datapath width: sample, fraction and headroom for growth and rounding
   localparam int CPR_DATA_WIDTH   = CPR_SAMPLE_WIDTH + CPR_FRAC + 3;
   // Rounded value before saturation
   localparam int CPR_ROUND_WIDTH  = CPR_DATA_WIDTH - CPR_FRAC;

   // Gain pre-correction 1/K in Q30
   localparam logic signed [31:0] CPR_INVK = 32'sh26DD3B6A;

   // Front stage, one cell per iteration, output stage
   localparam int CPR_LATENCY      = CPR_ITERS + 2;

   // atan(2^-i), full turn = 2^32
   localparam logic signed [CPR_ANGLE_WIDTH-1:0] CPR_ATAN_TAB [0:CPR_ITERS-1] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
      32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
      32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
      32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
      32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
   };

   typedef struct packed {
      logic signed [CPR_SAMPLE_WIDTH-1:0] in_real;
      logic signed [CPR_SAMPLE_WIDTH-1:0] in_imag;
      logic signed [CPR_PHASE_WIDTH-1:0]  phase;
   } cpr_req_type;

   typedef struct packed {
      logic signed [CPR_SAMPLE_WIDTH-1:0] out_real;
      logic signed [CPR_SAMPLE_WIDTH-1:0] out_imag;
   } cpr_rsp_type;

   // Data handed from cell to cell
   typedef struct packed {
      logic signed [CPR_DATA_WIDTH-1:0]  x;
      logic signed [CPR_DATA_WIDTH-1:0]  y;
      logic signed [CPR_ANGLE_WIDTH-1:0] z;
   } cpr_stage_type;

endpackage

`default_nettype wire

// ===== rtl/cpr_prerotate.sv =====
// ----------------------------------------------------------------------------
// cpr_prerotate: coarse quarter-turn rotation and gain pre-correction
// Rounds the angle to the nearest quarter turn, turns the sample exactly by
// it, scales both components by 1/K and leaves the residual angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_prerotate (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  cpr_pkg::cpr_req_type       req_data,
   output logic                       valid_ff,
   output cpr_pkg::cpr_stage_type     stage_ff
);
   import cpr_pkg::*;

   logic [CPR_ANGLE_WIDTH-1:0]        angle;
   logic [CPR_ANGLE_WIDTH-1:0]        angle_bias;
   logic [1:0]                        quad;
   logic [CPR_ANGLE_WIDTH-1:0]        resid;
   logic signed [CPR_QUAD_WIDTH-1:0]  re_ext;
   logic signed [CPR_QUAD_WIDTH-1:0]  im_ext;
   logic signed [CPR_QUAD_WIDTH-1:0]  xq;
   logic signed [CPR_QUAD_WIDTH-1:0]  yq;
   logic signed [CPR_PROD_WIDTH-1:0]  x_prod;
   logic signed [CPR_PROD_WIDTH-1:0]  y_prod;
   cpr_stage_type                     stage_in;

   // Phase scaled to a 2^32 turn, nearest quarter turn (ties up)
   assign angle      = CPR_ANGLE_WIDTH'(unsigned'(req_data.phase))
                       << (CPR_ANGLE_WIDTH - CPR_PHASE_WIDTH);
   assign angle_bias = angle + 32'h2000_0000;
   assign quad       = angle_bias[CPR_ANGLE_WIDTH-1 -: 2];
   assign resid      = angle - {quad, {(CPR_ANGLE_WIDTH-2){1'b0}}};

   assign re_ext = CPR_QUAD_WIDTH'(req_data.in_real);
   assign im_ext = CPR_QUAD_WIDTH'(req_data.in_imag);

   // Exact rotation by quad quarter turns
   always_comb begin
      case (quad)
         2'd1: begin
            xq = -im_ext;
            yq = re_ext;
         end
         2'd2: begin
            xq = -re_ext;
            yq = -im_ext;
         end
         2'd3: begin
            xq = im_ext;
            yq = -re_ext;
         end
         default: begin
            xq = re_ext;
            yq = im_ext;
         end
      endcase
   end

   // Gain pre-correction, exact product in Q30
   assign x_prod = xq * CPR_INVK;
   assign y_prod = yq * CPR_INVK;

   assign stage_in.x = CPR_DATA_WIDTH'(x_prod);
   assign stage_in.y = CPR_DATA_WIDTH'(y_prod);
   assign stage_in.z = signed'(resid);

   // Valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req_valid;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

// ===== rtl/cpr_cell.sv =====
// ----------------------------------------------------------------------------
// cpr_cell: one CORDIC rotation-mode iteration
// Turns the vector by +/- atan(2^-i) toward a zero residual and registers
// the result for the next cell in the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_cell (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [cpr_pkg::CPR_SHIFT_WIDTH-1:0]   shift_amt,
   input  wire logic signed [cpr_pkg::CPR_ANGLE_WIDTH-1:0] atan_step,
   input  wire logic                                  valid_prev,
   input  cpr_pkg::cpr_stage_type                     stage_prev,
   output logic                                       valid_ff,
   output cpr_pkg::cpr_stage_type                     stage_ff
);
   import cpr_pkg::*;

   logic signed [CPR_DATA_WIDTH-1:0] dx;
   logic signed [CPR_DATA_WIDTH-1:0] dy;
   cpr_stage_type                    stage_in;

   // Floor shifts of the cross terms
   assign dx = stage_prev.y >>> shift_amt;
   assign dy = stage_prev.x >>> shift_amt;

   // Direction from the sign of the residual
   always_comb begin
      if (stage_prev.z >= 0) begin
         stage_in.x = stage_prev.x - dx;
         stage_in.y = stage_prev.y + dy;
         stage_in.z = stage_prev.z - atan_step;
      end else begin
         stage_in.x = stage_prev.x + dx;
         stage_in.y = stage_prev.y - dy;
         stage_in.z = stage_prev.z + atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule

`default_nettype wire

// ===== rtl/cpr_finish.sv =====
// ----------------------------------------------------------------------------
// cpr_finish: output rounding and saturation
// Rounds each Q30 component to nearest (ties up) and clamps it to the
// sample range, then registers the response and its strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_finish (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  valid_prev,
   input  cpr_pkg::cpr_stage_type     stage_prev,
   output logic                       rsp_strobe_ff,
   output cpr_pkg::cpr_rsp_type       rsp_data_ff
);
   import cpr_pkg::*;

   localparam logic signed [CPR_ROUND_WIDTH-1:0] SAT_HI =
      CPR_ROUND_WIDTH'((64'sd1 <<< (CPR_SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [CPR_ROUND_WIDTH-1:0] SAT_LO =
      CPR_ROUND_WIDTH'(-(64'sd1 <<< (CPR_SAMPLE_WIDTH - 1)));
   localparam logic signed [CPR_DATA_WIDTH-1:0] HALF_LSB =
      CPR_DATA_WIDTH'(64'sd1 <<< (CPR_FRAC - 1));

   logic signed [CPR_DATA_WIDTH-1:0]  x_bias;
   logic signed [CPR_DATA_WIDTH-1:0]  y_bias;
   logic signed [CPR_ROUND_WIDTH-1:0] x_rnd;
   logic signed [CPR_ROUND_WIDTH-1:0] y_rnd;
   cpr_rsp_type                       rsp_data_in;

   // Round to nearest
   assign x_bias = stage_prev.x + HALF_LSB;
   assign y_bias = stage_prev.y + HALF_LSB;
   assign x_rnd  = x_bias[CPR_DATA_WIDTH-1:CPR_FRAC];
   assign y_rnd  = y_bias[CPR_DATA_WIDTH-1:CPR_FRAC];

   // Saturate to the sample range
   always_comb begin
      if (x_rnd > SAT_HI) begin
         rsp_data_in.out_real = SAT_HI[CPR_SAMPLE_WIDTH-1:0];
      end else if (x_rnd < SAT_LO) begin
         rsp_data_in.out_real = SAT_LO[CPR_SAMPLE_WIDTH-1:0];
      end else begin
         rsp_data_in.out_real = x_rnd[CPR_SAMPLE_WIDTH-1:0];
      end
      if (y_rnd > SAT_HI) begin
         rsp_data_in.out_imag = SAT_HI[CPR_SAMPLE_WIDTH-1:0];
      end else if (y_rnd < SAT_LO) begin
         rsp_data_in.out_imag = SAT_LO[CPR_SAMPLE_WIDTH-1:0];
      end else begin
         rsp_data_in.out_imag = y_rnd[CPR_SAMPLE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== rtl/complex_phase_rotator.sv =====
// ----------------------------------------------------------------------------
// complex_phase_rotator: CORDIC phase rotation of one complex sample
// Pipeline: one front stage, one cell per each of the 30 CORDIC iterations
// and one output stage lie between an accepted request and its rsp_strobe.
// Throughput: one request per cycle; busy is always low, the receiver cannot
// stall. Synchronous reset empties the chain; no request is in flight after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module complex_phase_rotator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  cpr_pkg::cpr_req_type   req_data,
   output logic                   rsp_strobe,
   output cpr_pkg::cpr_rsp_type   rsp_data
);
   import cpr_pkg::*;

   logic          req_valid;
   logic          chain_valid [0:CPR_ITERS];
   cpr_stage_type chain_stage [0:CPR_ITERS];

   // Fully pipelined: never busy
   assign busy      = 1'b0;
   assign req_valid = start & ~busy;

   // Quarter-turn rotation and gain
   cpr_prerotate u_prerotate (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .valid_ff  (chain_valid[0]),
      .stage_ff  (chain_stage[0])
   );

   // Chain of iteration cells
   for (genvar k = 0; k < CPR_ITERS; k++) begin : g_cell
      cpr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_amt  (CPR_SHIFT_WIDTH'(k)),
         .atan_step  (CPR_ATAN_TAB[k]),
         .valid_prev (chain_valid[k]),
         .stage_prev (chain_stage[k]),
         .valid_ff   (chain_valid[k+1]),
         .stage_ff   (chain_stage[k+1])
      );
   end

   // Round, saturate, register response
   cpr_finish u_finish (
      .clock         (clock),
      .reset         (reset),
      .valid_prev    (chain_valid[CPR_ITERS]),
      .stage_prev    (chain_stage[CPR_ITERS]),
      .rsp_strobe_ff (rsp_strobe),
      .rsp_data_ff   (rsp_data)
   );

`ifndef SYNTHESIS
   // Every response traces back to a request accepted outside reset
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !reset, CPR_LATENCY))
      else $error("response without a matching request");

   // A request accepted with no reset since gives a response
   a_req_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##CPR_LATENCY rsp_strobe)
      else $error("request lost in the cell chain");

   // Zero sample rotates to zero at any phase
   a_zero_sample : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_data.in_real == 0 && req_data.in_imag == 0, CPR_LATENCY)
      |-> rsp_data.out_real == 0 && rsp_data.out_imag == 0)
      else $error("zero sample gave a nonzero response");
`endif

endmodule

`default_nettype wire

// ===== dv/cpr_rotation_checker.sv =====
// ----------------------------------------------------------------------------
// cpr_rotation_checker: response checker for the complex phase rotator
// Watches the request and response channels. Every accepted request is run
// through a bit-exact fixed-point CORDIC model and queued; every strobed
// response is compared field by field with the oldest queued rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpr_rotation_checker
   import cpr_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   input  wire logic  busy,
   input  cpr_req_type req_data,
   input  wire logic  rsp_strobe,
   input  cpr_rsp_type rsp_data,
   output int         error_count,
   output int         outstanding,
   output int         checked_count
);

   localparam int     MAX_PRINTED  = 40;
   localparam int     CORDIC_STEPS = 30;
   localparam int     FRAC_BITS    = 30;
   // 1/K in Q30
   localparam longint INV_GAIN     = 64'sh26DD3B6A;
   localparam longint ROUND_HALF   = 64'sd1 <<< (FRAC_BITS - 1);
   localparam longint SAMPLE_MAX   = (64'sd1 <<< (CPR_SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_MIN   = -(64'sd1 <<< (CPR_SAMPLE_WIDTH - 1));

   cpr_rsp_type expected_rotations [$];
   cpr_rsp_type want;
   int          fail_total = 0;
   int          pending_total = 0;
   int          compared_total = 0;

   assign error_count   = fail_total;
   assign outstanding   = pending_total;
   assign checked_count = compared_total;

   // atan(2^-i), full turn = 2^32
   function automatic longint atan_turn32(input int i);
      case (i)
         0:  return 64'h20000000;
         1:  return 64'h12E4051E;
         2:  return 64'h09FB385B;
         3:  return 64'h051111D4;
         4:  return 64'h028B0D43;
         5:  return 64'h0145D7E1;
         6:  return 64'h00A2F61E;
         7:  return 64'h00517C55;
         8:  return 64'h0028BE53;
         9:  return 64'h00145F2F;
         10: return 64'h000A2F98;
         11: return 64'h000517CC;
         12: return 64'h00028BE6;
         13: return 64'h000145F3;
         14: return 64'h0000A2FA;
         15: return 64'h0000517D;
         16: return 64'h000028BE;
         17: return 64'h0000145F;
         18: return 64'h00000A30;
         19: return 64'h00000518;
         20: return 64'h0000028C;
         21: return 64'h00000146;
         22: return 64'h000000A3;
         23: return 64'h00000051;
         24: return 64'h00000029;
         25: return 64'h00000014;
         26: return 64'h0000000A;
         27: return 64'h00000005;
         28: return 64'h00000003;
         default: return 64'h00000001;
      endcase
   endfunction

   // Round to nearest (ties up), then clamp to the sample range
   function automatic logic [CPR_SAMPLE_WIDTH-1:0] round_saturate(input longint v);
      longint r;
      r = (v + ROUND_HALF) >>> FRAC_BITS;
      if (r > SAMPLE_MAX)
         r = SAMPLE_MAX;
      else if (r < SAMPLE_MIN)
         r = SAMPLE_MIN;
      return r[CPR_SAMPLE_WIDTH-1:0];
   endfunction

   // Expected rotation of one request
   function automatic cpr_rsp_type rotate_sample(input cpr_req_type req);
      longint      re;
      longint      im;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      logic [31:0] angle;
      logic [31:0] residual;
      logic [1:0]  quadrant;
      int          i;
      cpr_rsp_type rsp;
      re = req.in_real;
      im = req.in_imag;
      angle = {req.phase, {(32 - CPR_PHASE_WIDTH){1'b0}}};
      // nearest quarter turn, ties go up
      quadrant = 2'((angle + 32'h2000_0000) >> 30);
      residual = angle - {quadrant, 30'b0};
      z = longint'(signed'(residual));
      case (quadrant)
         2'd1: begin
            x = -im;
            y = re;
         end
         2'd2: begin
            x = -re;
            y = -im;
         end
         2'd3: begin
            x = im;
            y = -re;
         end
         default: begin
            x = re;
            y = im;
         end
      endcase
      x = x * INV_GAIN;
      y = y * INV_GAIN;
      for (i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_turn32(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_turn32(i);
         end
      end
      rsp.out_real = round_saturate(x);
      rsp.out_imag = round_saturate(y);
      return rsp;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_total < MAX_PRINTED)
         $display("[%0t] MISMATCH: %s", $time, msg);
      fail_total++;
   endtask

   // Compare responses first, then queue the request of this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_rotations.size() == 0) begin
               report_mismatch($sformatf("response (%0d, %0d) with no request outstanding",
                                         rsp_data.out_real, rsp_data.out_imag));
            end else begin
               want = expected_rotations.pop_front();
               if (rsp_data.out_real !== want.out_real)
                  report_mismatch($sformatf("response %0d out_real got %0d want %0d",
                                            compared_total, rsp_data.out_real, want.out_real));
               if (rsp_data.out_imag !== want.out_imag)
                  report_mismatch($sformatf("response %0d out_imag got %0d want %0d",
                                            compared_total, rsp_data.out_imag, want.out_imag));
               compared_total++;
            end
         end
         if (start && !busy)
            expected_rotations.push_back(rotate_sample(req_data));
         pending_total <= expected_rotations.size();
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the complex phase rotator
// Drives directed corner requests and then random requests under three
// sender idle profiles; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import cpr_pkg::*;

   localparam int CYCLE_LIMIT        = 200000;
   localparam int RANDOM_PER_PROFILE = 467;
   localparam int SW                 = CPR_SAMPLE_WIDTH;
   localparam int PW                 = CPR_PHASE_WIDTH;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   cpr_req_type req_data = '0;
   logic        busy;
   logic        rsp_strobe;
   cpr_rsp_type rsp_data;

   int error_count;
   int outstanding;
   int checked_count;
   int cycle_count = 0;
   int sent_count  = 0;
   int idle_pct    = 11;

   always #6 clock = ~clock;

   complex_phase_rotator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   cpr_rotation_checker rotation_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, outstanding);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Sample value biased toward the extremes and small magnitudes
   function automatic logic [SW-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return {1'b1, {(SW - 1){1'b0}}};
         1:       return {1'b0, {(SW - 1){1'b1}}};
         2, 3:    return SW'($urandom_range(16)) - SW'(8);
         default: return SW'($urandom);
      endcase
   endfunction

   // Present one request from a falling edge, hold it until accepted
   task automatic send_request(input cpr_req_type req);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   initial begin
      cpr_req_type item;
      int          profile;
      int          p;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero, full-scale, most negative, quarter and octant ties
      send_request('{16'sh0000, 16'sh0000, 16'sh0000});
      send_request('{16'sh7FFF, 16'sh0000, 16'sh0000});
      send_request('{16'sh7FFF, 16'sh0000, 16'sh4000});
      send_request('{16'sh7FFF, 16'sh0000, 16'sh8000});
      send_request('{16'sh7FFF, 16'sh0000, 16'shC000});
      send_request('{16'sh8000, 16'sh8000, 16'sh0000});
      send_request('{16'sh8000, 16'sh8000, 16'sh2000});
      send_request('{16'sh8000, 16'sh8000, 16'shA000});
      send_request('{16'sh7FFF, 16'sh7FFF, 16'sh2000});
      send_request('{16'sh8000, 16'sh7FFF, 16'sh4000});
      send_request('{16'sh8000, 16'sh0000, 16'sh8000});
      send_request('{16'sh0000, 16'sh8000, 16'shC000});
      send_request('{16'sh1234, 16'shEDCC, 16'sh2000});
      send_request('{16'sh1234, 16'shEDCC, 16'shE000});
      send_request('{16'sh1234, 16'shEDCC, 16'sh1FFF});
      send_request('{16'sh1234, 16'shEDCC, 16'sh6000});
      send_request('{16'sh1234, 16'shEDCC, 16'sh5FFF});
      send_request('{16'sh4000, 16'sh4000, 16'sh0001});
      send_request('{16'sh4000, 16'sh4000, 16'shFFFF});
      send_request('{16'sh4000, 16'sh4000, 16'sh7FFF});
      send_request('{16'sh0001, 16'shFFFF, 16'sh1555});
      send_request('{16'shFFFF, 16'sh0001, 16'shAAAA});
      send_request('{16'sh7FFF, 16'sh8000, 16'sh5555});

      // Random requests under each sender idle profile
      for (profile = 0; profile < 3; profile++) begin
         idle_pct = (profile == 0) ? 11 : (profile == 1) ? 61 : 0;
         repeat (RANDOM_PER_PROFILE) begin
            item.in_real = pick_sample();
            item.in_imag = pick_sample();
            // a quarter of the phases sit near an eighth-turn boundary
            if ($urandom_range(3) == 0) begin
               p = int'($urandom_range(7)) * (1 << (PW - 3)) + int'($urandom_range(6)) - 3;
               item.phase = PW'(p);
            end else begin
               item.phase = PW'($urandom);
            end
            send_request(item);
         end
      end
      start <= 1'b0;

      // Drain, then let the pipeline run empty
      while (outstanding != 0)
         @(posedge clock);
      repeat (CPR_LATENCY + 8) @(posedge clock);

      $display("Summary: %0d requests (directed corners, then random under 11%%, 61%% and 0%% idle)",
               sent_count);
      $display("Summary: %0d responses compared, %0d mismatches", checked_count, error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// ===== complex_phase_rotator.f =====
rtl/cpr_pkg.sv
rtl/cpr_prerotate.sv
rtl/cpr_cell.sv
rtl/cpr_finish.sv
rtl/complex_phase_rotator.sv
dv/cpr_rotation_checker.sv
dv/tb_top.sv
